### sv/aes_enc_pkg.sv
`timescale 1ns / 1ps

package aes_enc_pkg;

  localparam int ROUNDS   = 10;
  localparam int KEY_ROWS = ROUNDS + 1;
  localparam int KEY_AW   = $clog2(KEY_ROWS);
  localparam int KEY_COLS = 4;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ENCRYPT = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [5:0]  key_index;
    logic [31:0] key_value;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_word_t;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } out_word_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte n of the state sits at bits [127-8n -: 8], row n%4, column n/4
  function automatic logic [127:0] sub_shift(logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = SBOX[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] mix_column(logic [31:0] col);
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] d0, d1, d2, d3;
    a0 = col[31:24];
    a1 = col[23:16];
    a2 = col[15:8];
    a3 = col[7:0];
    d0 = xtime(a0);
    d1 = xtime(a1);
    d2 = xtime(a2);
    d3 = xtime(a3);
    return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
            a0 ^ d1 ^ d2 ^ a2 ^ a3,
            a0 ^ a1 ^ d2 ^ d3 ^ a3,
            d0 ^ a0 ^ a1 ^ a2 ^ d3};
  endfunction

  function automatic logic [127:0] mix_columns(logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      t[127 - 32*c -: 32] = mix_column(s[127 - 32*c -: 32]);
    end
    return t;
  endfunction

endpackage

### sv/aes_enc_ram.sv
`timescale 1ns / 1ps

module aes_enc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/aes_block_encrypt.sv
`timescale 1ns / 1ps

// channel   dir  handshake                    payload
// input     in   in_valid_i / in_ready_o      in_data_i  (aes_enc_pkg::in_word_t)
// output    out  out_valid_o / out_ready_i    out_data_o (aes_enc_pkg::out_word_t)
//
// a load word leaves the block idle, so it is ready again right after
// for an encrypt word the single round unit runs the initial
// key add and ten rounds, one per cycle, fed by one key row per cycle from
// four column rams; the last round waits while the output register is full
// in_ready_o is high only while idle; the output register lets the next word in
// asynchronous active-low reset clears control only; key store is not cleared

module aes_block_encrypt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  aes_enc_pkg::in_word_t in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output aes_enc_pkg::out_word_t out_data_o
);

  import aes_enc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e            fsm_q, fsm_d;
  logic [KEY_AW-1:0] round_q, round_d;
  logic [127:0]      blk_q, blk_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_data_q, out_data_d;

  logic              in_fire;
  logic              out_free;
  logic              last_round;
  logic              finish;
  logic [KEY_AW-1:0] key_raddr;
  logic [31:0]       key_word [KEY_COLS];
  logic [127:0]      round_key;
  logic [127:0]      ss_blk;
  logic [127:0]      mc_blk;
  logic [127:0]      round_out;
  logic              key_in_range;

  assign in_ready_o = (fsm_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_round = (round_q == KEY_AW'(ROUNDS));
  assign finish     = (fsm_q == ST_RUN) && last_round && out_free;

  // rows 11..15 of the index space are dropped
  assign key_in_range = (in_data_i.key_index[2 +: KEY_AW] < KEY_AW'(KEY_ROWS));

  // fetch one row ahead; hold the last row while the result stalls
  always_comb begin
    key_raddr = '0;
    if (fsm_q == ST_RUN) begin
      key_raddr = last_round ? round_q : round_q + KEY_AW'(1);
    end
  end

  for (genvar c = 0; c < KEY_COLS; c++) begin : g_key_col
    aes_enc_ram #(
      .WIDTH(32),
      .DEPTH(KEY_ROWS)
    ) u_key_ram (
      .clk_i   (clk_i),
      .we_i    (in_fire && (in_data_i.opcode == OP_LOAD) && key_in_range &&
                (in_data_i.key_index[1:0] == 2'(c))),
      .waddr_i (in_data_i.key_index[2 +: KEY_AW]),
      .wdata_i (in_data_i.key_value),
      .raddr_i (key_raddr),
      .rdata_o (key_word[c])
    );
  end

  assign round_key = {key_word[0], key_word[1], key_word[2], key_word[3]};

  // shared round unit
  assign ss_blk = sub_shift(blk_q);
  assign mc_blk = mix_columns(ss_blk);

  always_comb begin
    if (round_q == '0) begin
      round_out = blk_q ^ round_key;
    end else if (last_round) begin
      round_out = ss_blk ^ round_key;
    end else begin
      round_out = mc_blk ^ round_key;
    end
  end

  always_comb begin
    fsm_d       = fsm_q;
    round_d     = round_q;
    blk_d       = blk_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    unique case (fsm_q)
      ST_IDLE: begin
        if (in_fire && (in_data_i.opcode == OP_ENCRYPT)) begin
          fsm_d   = ST_RUN;
          round_d = '0;
          blk_d   = {in_data_i.block_hi, in_data_i.block_lo};
        end
      end
      ST_RUN: begin
        if (!last_round) begin
          blk_d   = round_out;
          round_d = round_q + KEY_AW'(1);
        end else if (finish) begin
          fsm_d       = ST_IDLE;
          out_valid_d = 1'b1;
          out_data_d  = '{cipher_hi: round_out[127:64], cipher_lo: round_out[63:0]};
        end
      end
      default: begin
        fsm_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_IDLE;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q      <= blk_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### sv/aes_enc_chk.sv
`timescale 1ns / 1ps

module aes_enc_chk (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input aes_enc_pkg::in_word_t  in_data_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input aes_enc_pkg::out_word_t out_data_o
);

  import aes_enc_pkg::*;

  logic enc_fire;
  logic load_fire;

  assign enc_fire  = in_valid_i && in_ready_o && (in_data_i.opcode == OP_ENCRYPT);
  assign load_fire = in_valid_i && in_ready_o && (in_data_i.opcode == OP_LOAD);

  // a pending result is neither dropped nor changed
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("output word dropped or changed while stalled");

  a_enc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enc_fire |=> !in_ready_o)
    else $error("input ready right after an encrypt word");

  a_enc_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enc_fire |-> ##11 !in_ready_o)
    else $error("encrypt finished in fewer than eleven cycles");

  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |=> in_ready_o)
    else $error("load word did not return to idle");

  // a new result appears together with the return to idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result appeared while still busy");

endmodule

bind aes_block_encrypt aes_enc_chk u_aes_enc_chk (.*);

### tb/sv/aes_block_encrypt_test.sv
`timescale 1ns / 1ps

module aes_block_encrypt_test;

  localparam int KEY_WORDS   = 4 * (aes_enc_pkg::ROUNDS + 1);
  localparam int RANDOM_ITEMS = 1600;
  localparam int unsigned CYCLE_LIMIT = 500_000;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  aes_enc_pkg::in_word_t  in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  aes_enc_pkg::out_word_t out_data_o;

  logic [7:0]  sbox_tab [256];
  logic [31:0] key_words [KEY_WORDS];
  aes_enc_pkg::out_word_t cipher_q [$];
  aes_enc_pkg::out_word_t cipher_seen;

  int          mismatches  = 0;
  int          items_sent  = 0;
  int          burst_left  = 0;
  int          rx_left     = 0;
  rx_mode_e    rx_mode     = RX_OPEN;
  int unsigned cycles      = 0;

  aes_block_encrypt dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // cipher arithmetic, state byte n at [127-8n -: 8], row n%4, column n/4

  function automatic logic [7:0] gf_mul(logic [7:0] x, logic [7:0] y);
    logic [7:0] p;
    logic [7:0] v;
    p = '0;
    v = x;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) p ^= v;
      v = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [127:0] round_key(int r);
    return {key_words[4*r], key_words[4*r+1], key_words[4*r+2], key_words[4*r+3]};
  endfunction

  function automatic logic [127:0] sub_rows(logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(4*c + r) -: 8] = sbox_tab[s[127 - 8*(4*((c + r) % 4) + r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a [4];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) a[i] = s[127 - 8*(4*c + i) -: 8];
      for (int i = 0; i < 4; i++) begin
        t[127 - 8*(4*c + i) -: 8] = gf_mul(a[i], 8'd2) ^ gf_mul(a[(i+1)%4], 8'd3)
                                    ^ a[(i+2)%4] ^ a[(i+3)%4];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] encrypt_block(logic [127:0] plain);
    logic [127:0] s;
    s = plain ^ round_key(0);
    for (int r = 1; r < aes_enc_pkg::ROUNDS; r++) s = mix_cols(sub_rows(s)) ^ round_key(r);
    return sub_rows(s) ^ round_key(aes_enc_pkg::ROUNDS);
  endfunction

  function automatic aes_enc_pkg::in_word_t fresh_word(aes_enc_pkg::opcode_e op);
    aes_enc_pkg::in_word_t w;
    w.opcode    = op;
    w.key_index = 6'($urandom);
    w.key_value = $urandom;
    w.block_hi  = {$urandom, $urandom};
    w.block_lo  = {$urandom, $urandom};
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // sender and result tracking

  task automatic send_word(input aes_enc_pkg::in_word_t w);
    aes_enc_pkg::out_word_t c;
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (w.opcode == aes_enc_pkg::OP_LOAD) begin
      if (w.key_index < KEY_WORDS) key_words[w.key_index] = w.key_value;
    end else begin
      {c.cipher_hi, c.cipher_lo} = encrypt_block({w.block_hi, w.block_lo});
      cipher_q.push_back(c);
    end
  endtask

  task automatic wait_for_ciphers();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_key_schedule(input logic [127:0] key, input bit shuffle,
                                   input bit raw);
    aes_enc_pkg::in_word_t w;
    logic [31:0] sched [KEY_WORDS];
    logic [31:0] t;
    logic [7:0]  rc;
    int          order [KEY_WORDS];
    int          j;
    int          tmp;
    rc = 8'h01;
    for (int i = 0; i < KEY_WORDS; i++) begin
      order[i] = i;
      if (raw) begin
        sched[i] = $urandom;
      end else if (i < 4) begin
        sched[i] = key[127 - 32*i -: 32];
      end else begin
        t = sched[i-1];
        if (i % 4 == 0) begin
          t = {t[23:0], t[31:24]};
          t = {sbox_tab[t[31:24]] ^ rc, sbox_tab[t[23:16]], sbox_tab[t[15:8]],
               sbox_tab[t[7:0]]};
          rc = gf_mul(rc, 8'd2);
        end
        sched[i] = sched[i-4] ^ t;
      end
    end
    if (shuffle) begin
      for (int i = KEY_WORDS - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    for (int i = 0; i < KEY_WORDS; i++) begin
      w = fresh_word(aes_enc_pkg::OP_LOAD);
      w.key_index = 6'(order[i]);
      w.key_value = sched[order[i]];
      send_word(w);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver stall pattern and result check

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 7) == 0);
      default:   out_ready_i <= (cycles % 6) < 3;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cipher_q.size() == 0) begin
        $error("unexpected cipher word %h", out_data_o);
        mismatches++;
      end else begin
        cipher_seen = cipher_q.pop_front();
        if (out_data_o.cipher_hi !== cipher_seen.cipher_hi) begin
          $error("cipher_hi: expected %h, got %h", cipher_seen.cipher_hi,
                 out_data_o.cipher_hi);
          mismatches++;
        end
        if (out_data_o.cipher_lo !== cipher_seen.cipher_lo) begin
          $error("cipher_lo: expected %h, got %h", cipher_seen.cipher_lo,
                 out_data_o.cipher_lo);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests

  task automatic test_known_vector();
    aes_enc_pkg::in_word_t w;
    load_key_schedule(128'h000102030405060708090a0b0c0d0e0f, 1'b0, 1'b0);
    if (encrypt_block(128'h00112233445566778899aabbccddeeff)
        !== 128'h69c4e0d86a7b0430d8cdb78070b4c55a) begin
      $error("cipher: expected %h, got %h", 128'h69c4e0d86a7b0430d8cdb78070b4c55a,
             encrypt_block(128'h00112233445566778899aabbccddeeff));
      mismatches++;
    end
    w = fresh_word(aes_enc_pkg::OP_ENCRYPT);
    {w.block_hi, w.block_lo} = 128'h00112233445566778899aabbccddeeff;
    send_word(w);
  endtask

  task automatic test_field_extremes();
    aes_enc_pkg::in_word_t w;
    // ignored key fields at their extremes on encrypt words
    w = fresh_word(aes_enc_pkg::OP_ENCRYPT);
    w.key_index = 6'd63;
    w.key_value = '1;
    w.block_hi  = '0;
    w.block_lo  = '0;
    send_word(w);
    w.key_index = 6'd0;
    w.key_value = '0;
    w.block_hi  = '1;
    w.block_lo  = '1;
    send_word(w);
    w.block_hi = {16{4'h5}};
    w.block_lo = {16{4'ha}};
    send_word(w);
    // loads at both ends of the store, block fields ignored
    w = fresh_word(aes_enc_pkg::OP_LOAD);
    w.key_index = 6'd0;
    w.key_value = '0;
    w.block_hi  = '1;
    w.block_lo  = '1;
    send_word(w);
    w.key_index = 6'(KEY_WORDS - 1);
    w.key_value = '1;
    w.block_hi  = '0;
    w.block_lo  = '0;
    send_word(w);
    send_word(fresh_word(aes_enc_pkg::OP_ENCRYPT));
    // out of range indexes leave the store alone
    w = fresh_word(aes_enc_pkg::OP_LOAD);
    w.key_index = 6'(KEY_WORDS);
    send_word(w);
    w = fresh_word(aes_enc_pkg::OP_LOAD);
    w.key_index = 6'd63;
    send_word(w);
    w = fresh_word(aes_enc_pkg::OP_ENCRYPT);
    w.block_hi = '0;
    w.block_lo = '1;
    send_word(w);
  endtask

  task automatic test_drain_pause();
    aes_enc_pkg::in_word_t w;
    repeat (4) send_word(fresh_word(aes_enc_pkg::OP_ENCRYPT));
    wait_for_ciphers();
    // key word used right after it is written
    w = fresh_word(aes_enc_pkg::OP_LOAD);
    w.key_index = 6'($urandom_range(0, KEY_WORDS - 1));
    send_word(w);
    send_word(fresh_word(aes_enc_pkg::OP_ENCRYPT));
    wait_for_ciphers();
  endtask

  task automatic test_random_traffic();
    aes_enc_pkg::in_word_t w;
    int pick;
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
        load_key_schedule({$urandom, $urandom, $urandom, $urandom},
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick < 3) begin
        wait_for_ciphers();
      end else if (pick < 27) begin
        w = fresh_word(aes_enc_pkg::OP_LOAD);
        w.key_index = 6'($urandom_range(0, KEY_WORDS - 1));
        send_word(w);
      end else if (pick < 33) begin
        w = fresh_word(aes_enc_pkg::OP_LOAD);
        w.key_index = 6'($urandom_range(KEY_WORDS, 63));
        send_word(w);
      end else begin
        send_word(fresh_word(aes_enc_pkg::OP_ENCRYPT));
      end
    end
  endtask

  initial begin
    logic [7:0] inv;
    logic [7:0] rot;
    logic [7:0] sb;
    // s-box from the field inverse and the affine map
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      end
      sb  = inv ^ 8'h63;
      rot = inv;
      repeat (4) begin
        rot = {rot[6:0], rot[7]};
        sb ^= rot;
      end
      sbox_tab[x] = sb;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_known_vector();
    test_field_extremes();
    test_drain_pause();
    test_random_traffic();

    wait_for_ciphers();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
